// ===== rtl/core/fccs_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain step core.
// No dependencies; imported by fccs_div and fat12_cluster_chain_step_core.
`default_nettype none

package fccs_pkg;

	// Default table store size in bytes
	localparam int TABLE_BYTES_DEF = 8192;

	// Field widths
	localparam int ADDR_W    = 13;
	localparam int BYTE_W    = 8;
	localparam int CLUS_W    = 12;
	localparam int SECTOR_W  = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Width of the root directory size in bytes: root_entries * 32
	localparam int ROOT_BYTES_W = 21;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAT_COPIES       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAT_SECTORS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRIES     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS  = 3'd5;

	// Register reset values
	localparam logic [15:0] RESERVED_SECTORS_RST = 16'd1;
	localparam logic [7:0]  FAT_COPIES_RST       = 8'd2;
	localparam logic [15:0] FAT_SECTORS_RST      = 16'd9;
	localparam logic [15:0] ROOT_ENTRIES_RST     = 16'd224;
	localparam logic [15:0] SECTOR_BYTES_RST     = 16'd512;
	localparam logic [7:0]  CLUSTER_SECTORS_RST  = 8'd1;

	// Item kind carried on tuser
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_FOLLOW = 1'b1;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fccs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/fccs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fccs_pkg (div_status_t).
`default_nettype none

module fccs_div #(
	parameter int N_W = 21,
	parameter int D_W = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [N_W-1:0]             dividend,
	input  wire [D_W-1:0]             divisor,
	output logic [N_W-1:0]            quotient,
	output fccs_pkg::div_status_t     status
);

	import fccs_pkg::*;

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W:0]     rem_q;
	logic [N_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0] shifted;
	logic         ge;

	// One restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		shifted = {rem_q[D_W-1:0], quo_q[N_W-1]};
		ge      = (shifted >= {1'b0, divisor});
	end

	// Step counter and busy/done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, divisor}) : shifted;
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/fat12_cluster_chain_step_core.sv =====
// FAT12 cluster chain step core: table byte store, first-sector and next-cluster lookup.
// Depends on fccs_pkg, fccs_ram and fccs_div.
// Write item: ready again for the next item. Follow item: steps through ST_RD_LO,
// ST_RD_HI and ST_CAP for the two table reads, loads the result when the output is free
// and takes the next item in ST_IDLE. After reset and after every configuration write
// the core is busy as the divider forms the root directory sectors and constant base.
// Reset: asynchronous, active low; config registers take default values, output is empty.
`default_nettype none

module fat12_cluster_chain_step_core #(
	parameter int TABLE_BYTES = fccs_pkg::TABLE_BYTES_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// Input stream
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [39:0]                     s_tdata,   // table_addr[12:0], table_byte[20:13],
	                                                  // cluster[32:21], zero[39:33]
	input  wire                            s_tuser,   // func
	// Result stream
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [47:0]                    m_tdata,   // first_sector[31:0],
	                                                  // next_cluster[43:32], zero[47:44]
	// Configuration write port
	input  wire                            cfg_we,
	input  wire [fccs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [fccs_pkg::CFG_W-1:0]      cfg_wdata
);

	import fccs_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RD_LO = 2'd1;
	localparam logic [1:0] ST_RD_HI = 2'd2;
	localparam logic [1:0] ST_CAP   = 2'd3;

	// Input fields
	logic              in_func;
	logic [ADDR_W-1:0] in_addr;
	logic [BYTE_W-1:0] in_byte;
	logic [CLUS_W-1:0] in_clus;

	assign in_func = s_tuser;
	assign in_addr = s_tdata[12:0];
	assign in_byte = s_tdata[20:13];
	assign in_clus = s_tdata[32:21];

	// Configuration registers
	logic [15:0] reserved_q;
	logic [7:0]  copies_q;
	logic [15:0] fat_secs_q;
	logic [15:0] root_ent_q;
	logic [15:0] sec_bytes_q;
	logic [7:0]  clus_secs_q;
	logic        prep_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q  <= RESERVED_SECTORS_RST;
			copies_q    <= FAT_COPIES_RST;
			fat_secs_q  <= FAT_SECTORS_RST;
			root_ent_q  <= ROOT_ENTRIES_RST;
			sec_bytes_q <= SECTOR_BYTES_RST;
			clus_secs_q <= CLUSTER_SECTORS_RST;
			prep_pend_q <= 1'b1;
		end else begin
			prep_pend_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_RESERVED_SECTORS: reserved_q  <= cfg_wdata;
					REG_FAT_COPIES:       copies_q    <= cfg_wdata[7:0];
					REG_FAT_SECTORS:      fat_secs_q  <= cfg_wdata;
					REG_ROOT_ENTRIES:     root_ent_q  <= cfg_wdata;
					REG_SECTOR_BYTES:     sec_bytes_q <= cfg_wdata;
					REG_CLUSTER_SECTORS:  clus_secs_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
		end
	end

	// Root directory sectors: (root_entries * 32) / sector_bytes
	logic [ROOT_BYTES_W-1:0] div_quo;
	div_status_t             div_st;

	fccs_div #(
		.N_W (ROOT_BYTES_W),
		.D_W (16)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (prep_pend_q),
		.dividend ({root_ent_q, 5'd0}),
		.divisor  (sec_bytes_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// Constant part of the first sector, minus the sectors of the two reserved cluster numbers
	logic [23:0]             cf_prod_q;
	logic [SECTOR_W-1:0]     base_q;
	logic [ROOT_BYTES_W-1:0] root_secs;

	assign root_secs = (sec_bytes_q == 16'd0) ? '0 : div_quo;

	always_ff @(posedge clk) begin
		cf_prod_q <= 24'(copies_q) * 24'(fat_secs_q);
		if (div_st.done) begin
			base_q <= SECTOR_W'(reserved_q) + SECTOR_W'(cf_prod_q) + SECTOR_W'(root_secs)
			          - {23'd0, clus_secs_q, 1'b0};
		end
	end

	// Follow sequencer
	logic [1:0]          state_q;
	logic [CLUS_W-1:0]   clus_q;
	logic [19:0]         prod_q;
	logic [SECTOR_W-1:0] sum_q;
	logic [BYTE_W-1:0]   lo_q;
	logic                out_valid_q;
	logic [SECTOR_W-1:0] out_sector_q;
	logic [CLUS_W-1:0]   out_next_q;

	logic                in_xfer;
	logic                out_free;
	logic [ADDR_W-1:0]   entry_at;
	logic [15:0]         pair;
	logic [BYTE_W-1:0]   ram_rdata;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;

	assign s_tready = (state_q == ST_IDLE) && !prep_pend_q && !div_st.busy && !div_st.done;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Entry starts at cluster + cluster/2; the pair never passes byte 6143
	assign entry_at  = {1'b0, clus_q} + {2'b0, clus_q[CLUS_W-1:1]};
	assign ram_raddr = (state_q == ST_RD_LO) ? AW'(entry_at) : AW'(entry_at + ADDR_W'(1));
	assign ram_we    = in_xfer && (in_func == FUNC_WRITE)
	                   && ({{(32 - ADDR_W){1'b0}}, in_addr} < 32'(TABLE_BYTES));
	assign pair      = {ram_rdata, lo_q};

	fccs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_BYTES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_addr)),
		.wdata (in_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (in_func == FUNC_FOLLOW)) begin
						state_q <= ST_RD_LO;
					end
				end
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: state_q <= ST_CAP;
				ST_CAP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: product, low byte and sum, then the result register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			clus_q <= in_clus;
		end
		if (state_q == ST_RD_LO) begin
			prod_q <= 20'(clus_secs_q) * 20'(clus_q);
		end
		if (state_q == ST_RD_HI) begin
			lo_q  <= ram_rdata;
			sum_q <= base_q + SECTOR_W'(prod_q);
		end
		if ((state_q == ST_CAP) && out_free) begin
			out_sector_q <= sum_q;
			out_next_q   <= clus_q[0] ? pair[15:4] : pair[11:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_next_q, out_sector_q};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the FAT12 cluster chain step core.
// Depends on fccs_pkg and fat12_cluster_chain_step_core; predicts every lookup result itself.
`timescale 1ns / 100ps

module testbench;
	import fccs_pkg::*;

	localparam int TABLE_BYTES    = TABLE_BYTES_DEF;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int PHASE_ITEMS    = 250;
	localparam int MAX_REPORTS    = 10;

	// Register indexes the core does not decode
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [SECTOR_W-1:0] first_sector;
		logic [CLUS_W-1:0]   next_cluster;
	} chain_result_t;

	// DUT connections
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [39:0]          s_tdata;    // table_addr[12:0], table_byte[20:13], cluster[32:21], zero
	logic                 s_tuser;    // func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [47:0]          m_tdata;    // first_sector[31:0], next_cluster[43:32], zero
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// Predictor state: volume geometry and table image
	logic [15:0] vol_reserved        = RESERVED_SECTORS_RST;
	logic [7:0]  vol_fat_copies      = FAT_COPIES_RST;
	logic [15:0] vol_fat_sectors     = FAT_SECTORS_RST;
	logic [15:0] vol_root_entries    = ROOT_ENTRIES_RST;
	logic [15:0] vol_sector_bytes    = SECTOR_BYTES_RST;
	logic [7:0]  vol_cluster_sectors = CLUSTER_SECTORS_RST;
	logic [7:0]  table_mem [0:TABLE_BYTES-1];
	bit          table_written [0:TABLE_BYTES-1];

	chain_result_t chain_expect[$];
	logic [CLUS_W-1:0] last_next = '0;

	// Run control and bookkeeping
	bit rush    = 1'b0;
	bit rx_hold = 1'b0;
	int n_items   = 0;
	int n_writes  = 0;
	int n_lookups = 0;
	int n_results = 0;
	int n_configs = 0;
	int n_errors  = 0;
	int cycle_cnt = 0;

	fat12_cluster_chain_step_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles", cycle_cnt);
		$display("Verification failed");
		$finish;
	end

	// Gap before a transfer on either side
	function automatic int draw_idle();
		if (rush)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [15:0] pick_cfg(input int lo, input int hi);
		case ($urandom_range(0, 7))
			0: return lo[15:0];
			1: return hi[15:0];
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	// First sector and next cluster for one lookup
	function automatic chain_result_t lookup_chain(input logic [CLUS_W-1:0] clus);
		chain_result_t r;
		logic [31:0]   root_secs;
		logic [31:0]   at;
		logic [15:0]   pair;
		if (vol_sector_bytes == 16'd0)
			root_secs = 32'd0;
		else
			root_secs = {11'd0, vol_root_entries, 5'd0} / {16'd0, vol_sector_bytes};
		r.first_sector = {16'd0, vol_reserved}
			+ {24'd0, vol_fat_copies} * {16'd0, vol_fat_sectors}
			+ root_secs
			+ {24'd0, vol_cluster_sectors} * ({20'd0, clus} - 32'd2);
		at = {20'd0, clus} + {21'd0, clus[CLUS_W-1:1]};
		pair = {table_mem[at + 1], table_mem[at]};
		r.next_cluster = clus[0] ? pair[15:4] : pair[11:0];
		return r;
	endfunction

	function automatic bit [ADDR_W-1:0] entry_addr(input logic [CLUS_W-1:0] clus);
		return {1'b0, clus} + {2'b0, clus[CLUS_W-1:1]};
	endfunction

	// One input transfer; the prediction is taken at acceptance
	task automatic send_item(input logic func, input logic [ADDR_W-1:0] taddr,
		input logic [BYTE_W-1:0] tbyte, input logic [CLUS_W-1:0] clus);
		int gap;
		chain_result_t r;
		gap = draw_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {7'd0, clus, tbyte, taddr};
		do @(posedge clk); while (!s_tready);
		n_items++;
		if (func == FUNC_WRITE) begin
			if (int'(taddr) < TABLE_BYTES) begin
				table_mem[taddr]     = tbyte;
				table_written[taddr] = 1'b1;
			end
			n_writes++;
		end else begin
			r = lookup_chain(clus);
			chain_expect.push_back(r);
			last_next = r.next_cluster;
			n_lookups++;
		end
	endtask

	// Lookup of a cluster; its entry bytes are written first when missing or now and then
	task automatic send_lookup(input logic [CLUS_W-1:0] clus);
		bit [ADDR_W-1:0] at;
		at = entry_addr(clus);
		if (!table_written[at] || $urandom_range(0, 3) == 0)
			send_item(FUNC_WRITE, at, BYTE_W'($urandom), CLUS_W'($urandom));
		if (!table_written[at + 1] || $urandom_range(0, 3) == 0)
			send_item(FUNC_WRITE, at + ADDR_W'(1), BYTE_W'($urandom), CLUS_W'($urandom));
		send_item(FUNC_FOLLOW, ADDR_W'($urandom), BYTE_W'($urandom), clus);
	endtask

	// Stop offering, wait for every result, then let the core settle
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (chain_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_RESERVED_SECTORS: vol_reserved        = val;
			REG_FAT_COPIES:       vol_fat_copies      = val[7:0];
			REG_FAT_SECTORS:      vol_fat_sectors     = val;
			REG_ROOT_ENTRIES:     vol_root_entries    = val;
			REG_SECTOR_BYTES:     vol_sector_bytes    = val;
			REG_CLUSTER_SECTORS:  vol_cluster_sectors = val[7:0];
			default: ;
		endcase
	endtask

	// Full geometry update, only with the core idle
	task automatic program_volume(input logic [15:0] rs, input logic [7:0] fc,
		input logic [15:0] fs, input logic [15:0] re, input logic [15:0] sb,
		input logic [7:0] cs);
		wait_drain();
		reg_write(REG_RESERVED_SECTORS, rs);
		reg_write(REG_FAT_COPIES, {8'd0, fc});
		reg_write(REG_FAT_SECTORS, fs);
		reg_write(REG_ROOT_ENTRIES, re);
		reg_write(REG_SECTOR_BYTES, sb);
		reg_write(REG_CLUSTER_SECTORS, {8'd0, cs});
		reg_write($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, CFG_W'($urandom));
		cfg_we <= 1'b0;
		n_configs++;
	endtask

	// Typical table head, looked up with the reset geometry
	task automatic test_reset_values();
		send_item(FUNC_WRITE, 13'd0, 8'hF0, 12'hFFF);
		send_item(FUNC_WRITE, 13'd1, 8'hFF, 12'h000);
		send_item(FUNC_WRITE, 13'd2, 8'hFF, 12'hAAA);
		send_item(FUNC_WRITE, 13'd3, 8'h03, 12'h555);
		send_item(FUNC_WRITE, 13'd4, 8'h40, 12'h000);
		send_item(FUNC_WRITE, 13'd5, 8'h00, 12'hFFF);
		send_item(FUNC_FOLLOW, 13'h1FFF, 8'hFF, 12'd0);
		send_item(FUNC_FOLLOW, 13'h0000, 8'h00, 12'd1);
		send_item(FUNC_FOLLOW, 13'h0AAA, 8'h55, 12'd2);
		send_item(FUNC_FOLLOW, 13'h1555, 8'hAA, 12'd3);
	endtask

	// Last entries of a full-size table and the top of the store
	task automatic test_table_edges();
		send_item(FUNC_WRITE, 13'd6141, 8'hA5, 12'hFFF);
		send_item(FUNC_WRITE, 13'd6142, 8'h5A, 12'h000);
		send_item(FUNC_WRITE, 13'd6143, 8'hFF, 12'h123);
		send_item(FUNC_WRITE, 13'h1FFF, 8'hFF, 12'hFFF);
		send_item(FUNC_FOLLOW, 13'h1FFF, 8'h00, 12'd4094);
		send_item(FUNC_FOLLOW, 13'h0000, 8'hFF, 12'd4095);
	endtask

	// Largest geometry, then the zero sector size and wrap below cluster two, then one-byte sectors
	task automatic test_config_extremes();
		program_volume(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd0);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd4095);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd2);
		program_volume(16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 8'd1);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd0);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd1);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd2);
		program_volume(16'd0, 8'd0, 16'd0, 16'hFFFF, 16'd1, 8'hFF);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd1);
		send_item(FUNC_FOLLOW, 13'd0, 8'd0, 12'd4094);
	endtask

	// Results held back long enough for the core to stall its input
	task automatic test_backpressure();
		int i;
		rx_hold = 1'b1;
		rush    = 1'b1;
		for (i = 0; i < 48; i++)
			send_lookup(CLUS_W'($urandom));
		rush = 1'b0;
		wait_drain();
	endtask

	// Random geometry per phase; lookups along the chain, at edge and at random clusters, some stray writes
	task automatic test_random_phases();
		int phase;
		int target;
		bit paused;
		logic [CLUS_W-1:0] c;
		for (phase = 0; phase < 6; phase++) begin
			program_volume(pick_cfg(0, 65535), 8'(pick_cfg(0, 255)), pick_cfg(0, 65535),
				pick_cfg(0, 65535), pick_cfg(1, 65535), 8'(pick_cfg(1, 255)));
			rush   = (phase == 2);
			paused = 1'b0;
			target = n_items + PHASE_ITEMS;
			while (n_items < target) begin
				if (!paused && n_items > target - PHASE_ITEMS / 2) begin
					// sender waits until every result has come
					wait_drain();
					paused = 1'b1;
				end
				case ($urandom_range(0, 19))
					0, 1, 2:
						send_item(FUNC_WRITE, ADDR_W'($urandom), BYTE_W'($urandom),
							CLUS_W'($urandom));
					3, 4, 5, 6, 7, 8:
						send_lookup(last_next);
					9, 10: begin
						case ($urandom_range(0, 3))
							0: c = 12'd0;
							1: c = 12'd1;
							2: c = 12'd4095;
							default: c = 12'd4094;
						endcase
						send_lookup(c);
					end
					default:
						send_lookup(CLUS_W'($urandom));
				endcase
			end
			rush = 1'b0;
		end
	endtask

	// Result receiver: random stalls, one long hold on request
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else begin
				stall = draw_idle();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic flag_mismatch(input string msg);
		if (n_errors < MAX_REPORTS)
			$display("Mismatch at cycle %0d: %s", cycle_cnt, msg);
		n_errors++;
	endtask

	// Result checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		chain_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (chain_expect.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = chain_expect.pop_front();
				if (m_tdata[31:0] !== want.first_sector)
					flag_mismatch($sformatf("first_sector expected %h got %h",
						want.first_sector, m_tdata[31:0]));
				if (m_tdata[43:32] !== want.next_cluster)
					flag_mismatch($sformatf("next_cluster expected %h got %h",
						want.next_cluster, m_tdata[43:32]));
			end
		end
	end

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_WRITE;
		cfg_we    <= 1'b0;
		cfg_index <= REG_RESERVED_SECTORS;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_table_edges();
		test_config_extremes();
		test_backpressure();
		test_random_phases();
		wait_drain();
		$display("Sent %0d table writes and %0d chain lookups over %0d geometries",
			n_writes, n_lookups, n_configs);
		$display("Checked %0d results, %0d mismatches", n_results, n_errors);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fccs_pkg.sv
rtl/core/fccs_ram.sv
rtl/core/fccs_div.sv
rtl/core/fat12_cluster_chain_step_core.sv
tb/testbench.sv
